FILE: design/psf_resize_quadrant_taper_macros.svh
// assertion macros shared by the resize/taper block
// needs a clk and a rst signal in the scope where a macro is used
`ifndef PSF_RESIZE_QUADRANT_TAPER_MACROS_SVH
`define PSF_RESIZE_QUADRANT_TAPER_MACROS_SVH

// condition holds in the same cycle
`define PRQT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define PRQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/psf_rqt_pkg.sv
// shared types, constants and register codes for the resize/taper block
// no dependencies
`timescale 1ns / 1ps

package psf_rqt_pkg;

  localparam int MAX_DIM    = 256;
  localparam int MAX_PLANES = 64;

  // register indexes on the write port
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_NUM_COEFFS = 3'd4;

  // queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // back pipeline layout
  localparam int BK_STAGES   = 32;
  localparam int SQRT_LAST   = 12;
  localparam int DIV_FIRST   = 13;
  localparam int DIV_LAST    = 21;
  localparam int ST_T        = 22;
  localparam int ST_W        = 23;
  localparam int ST_P4       = 24;
  localparam int ST_P1       = 27;
  localparam int ST_C        = 28;
  localparam int ST_FACTOR   = 29;
  localparam int ST_SCALE    = 30;
  localparam int ST_SIGN     = 31;

  // cosine polynomial, Q30
  localparam logic [30:0] COS_A1  = 31'd1324675879;
  localparam logic [30:0] COS_A2  = 31'd272375563;
  localparam logic [30:0] COS_A3  = 31'd22401989;
  localparam logic [30:0] COS_A4  = 31'd987048;
  localparam logic [30:0] COS_A5  = 31'd27061;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  localparam logic [26:0] T_OFFSET = 27'd196608;
  localparam logic [16:0] T_MAX    = 17'd65536;

  // clamped configuration
  typedef struct packed {
    logic [8:0] sw;
    logic [8:0] sh;
    logic [8:0] dw;
    logic [8:0] dh;
    logic [6:0] nc;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]  nx;
    logic [7:0]  ny;
    logic [15:0] idx;
    logic [5:0]  plane;
    logic [31:0] raw;
    logic        zero;
    logic        taper;
    logic [15:0] r2;
  } fr_t;

  // working set of one back stage
  typedef struct packed {
    logic [7:0]  nx;
    logic [7:0]  ny;
    logic [15:0] idx;
    logic [5:0]  plane;
    logic        neg;
    logic        zero;
    logic        taper;
    logic [31:0] mag;
    logic [47:0] rem;
    logic [23:0] root;
    logic [9:0]  drem;
    logic [26:0] dq;
    logic [16:0] t;
    logic [30:0] w;
    logic [30:0] p;
    logic [30:0] c;
    logic [15:0] f;
  } bk_t;

endpackage

FILE: design/psf_rqt_front.sv
// front: accepts input beats, maps them to the new grid, drops the rest
// depends on psf_rqt_pkg
`timescale 1ns / 1ps

module psf_rqt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  psf_rqt_pkg::cfg_t             cfg,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [55:0]                   s_tdata,   // src_x, src_y, plane, pixel_value
  input  logic [psf_rqt_pkg::Q_CW-1:0]  q_count,
  output logic                          push,
  output psf_rqt_pkg::fr_t              push_data
);

  // one axis of the wrap-around remap
  function automatic logic [8:0] map_axis(input logic [7:0] c, input logic [8:0] src,
                                          input logic [8:0] dst);
    logic [8:0]  half;
    logic [10:0] n;
    logic        keep;
    half = ((dst > src) ? src : dst) >> 1;
    n    = {3'b0, c} + {2'b0, dst} - {2'b0, src};
    keep = 1'b0;
    if ({1'b0, c} < src) begin
      if ({1'b0, c} < half) keep = 1'b1;
      else if (!n[10] && (n >= {2'b0, half})) keep = 1'b1;
    end
    map_axis = {keep, ({1'b0, c} < half) ? c : n[7:0]};
  endfunction

  logic       accept;
  logic [8:0] mx, my;
  logic       keep_a;

  logic        va;
  logic [7:0]  nx_a, ny_a;
  logic [5:0]  plane_a;
  logic [31:0] raw_a;

  logic        vb;

  // credit: queue entries plus items still in the two front stages
  logic [psf_rqt_pkg::Q_CW:0] credit;
  assign credit   = {1'b0, q_count} + (psf_rqt_pkg::Q_CW + 1)'(va)
                  + (psf_rqt_pkg::Q_CW + 1)'(vb);
  assign s_tready = credit < (psf_rqt_pkg::Q_CW + 1)'(psf_rqt_pkg::Q_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // classification at the input
  always_comb begin
    mx     = map_axis(s_tdata[7:0], cfg.sw, cfg.dw);
    my     = map_axis(s_tdata[15:8], cfg.sh, cfg.dh);
    keep_a = ({1'b0, s_tdata[21:16]} < cfg.nc) && mx[8] && my[8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= accept && keep_a;
    end
  end

  always_ff @(posedge clk) begin
    nx_a    <= mx[7:0];
    ny_a    <= my[7:0];
    plane_a <= s_tdata[21:16];
    raw_a   <= s_tdata[53:22];
  end

  // corner distance and radius tests
  logic [8:0]  ex, ey;
  logic [7:0]  dx, dy;
  logic [16:0] r2;
  logic [17:0] w2;
  logic [16:0] idx_full;

  always_comb begin
    ex       = cfg.dw - {1'b0, nx_a};
    ey       = cfg.dh - {1'b0, ny_a};
    dx       = (ex < {1'b0, nx_a}) ? ex[7:0] : nx_a;
    dy       = (ey < {1'b0, ny_a}) ? ey[7:0] : ny_a;
    r2       = 17'({8'b0, dx} * {8'b0, dx}) + 17'({8'b0, dy} * {8'b0, dy});
    w2       = 18'({9'b0, cfg.sw} * {9'b0, cfg.sw});
    idx_full = 17'({9'b0, ny_a} * {8'b0, cfg.dw}) + {9'b0, nx_a};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    push_data.nx    <= nx_a;
    push_data.ny    <= ny_a;
    push_data.idx   <= idx_full[15:0];
    push_data.plane <= plane_a;
    push_data.raw   <= raw_a;
    push_data.zero  <= {r2, 2'b0} > {1'b0, w2};
    push_data.taper <= {r2, 6'b0} > (23'({5'b0, w2}) * 23'd9);
    push_data.r2    <= r2[15:0];
  end

  assign push = vb;

endmodule

FILE: design/psf_rqt_queue.sv
// queue: short register fifo between the front and the back
// depends on psf_rqt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "psf_resize_quadrant_taper_macros.svh"

module psf_rqt_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  psf_rqt_pkg::fr_t              push_data,
  input  logic                          pop,
  output logic                          q_valid,
  output psf_rqt_pkg::fr_t              q_data,
  output logic [psf_rqt_pkg::Q_CW-1:0]  count
);

  psf_rqt_pkg::fr_t              mem [psf_rqt_pkg::Q_DEPTH];
  logic [psf_rqt_pkg::Q_AW-1:0]  wr_ptr, rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign q_valid = count != '0;
  assign q_data  = mem[rd_ptr];

  `PRQT_ASSERT_NOW(a_no_overflow, push && !pop, count < psf_rqt_pkg::Q_CW'(psf_rqt_pkg::Q_DEPTH), "queue overflow")
  `PRQT_ASSERT_NOW(a_no_underflow, pop, count != '0, "pop from empty queue")
  `PRQT_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "fill count lost a push")

endmodule

FILE: design/psf_rqt_back.sv
// back: taper pipeline (square root, divide, cosine polynomial, scale)
// depends on psf_rqt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "psf_resize_quadrant_taper_macros.svh"

module psf_rqt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [8:0]        sw,
  input  logic              q_valid,
  input  psf_rqt_pkg::fr_t  q_data,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata    // dst_x, dst_y, dst_index, out_plane, tapered_value
);

  localparam int NS = psf_rqt_pkg::BK_STAGES;

  // one pipeline stage, selected by its position
  function automatic psf_rqt_pkg::bk_t stage_fn(input psf_rqt_pkg::bk_t a, input int i,
                                                input logic [8:0] dsor);
    psf_rqt_pkg::bk_t b;
    logic [49:0] d;
    logic [61:0] prod;
    logic [30:0] coef;
    logic [30:0] pin;
    logic [32:0] cs;
    logic [47:0] sc;
    logic [26:0] tdiff;
    logic [33:0] tt;
    int          k;
    b    = a;
    coef = psf_rqt_pkg::COS_A1;
    if (i <= psf_rqt_pkg::SQRT_LAST) begin
      // two root bits per stage
      for (int j = 0; j < 2; j++) begin
        k = 25 - 2 * i - j;
        d = ({26'b0, b.root} << (k + 1)) + (50'd1 << (2 * k));
        if ({2'b0, b.rem} >= d) begin
          b.rem  = b.rem - d[47:0];
          b.root = b.root | (24'd1 << k);
        end
      end
    end else if (i <= psf_rqt_pkg::DIV_LAST) begin
      // three quotient bits per stage, restoring
      if (i == psf_rqt_pkg::DIV_FIRST) begin
        b.dq   = {b.root, 3'b0};
        b.drem = '0;
      end
      for (int j = 0; j < 3; j++) begin
        b.drem = {b.drem[8:0], b.dq[26]};
        b.dq   = {b.dq[25:0], 1'b0};
        if (b.drem >= {1'b0, dsor}) begin
          b.drem  = b.drem - {1'b0, dsor};
          b.dq[0] = 1'b1;
        end
      end
    end else if (i == psf_rqt_pkg::ST_T) begin
      tdiff = b.dq - psf_rqt_pkg::T_OFFSET;
      if (b.dq < psf_rqt_pkg::T_OFFSET) b.t = '0;
      else if (tdiff > {10'b0, psf_rqt_pkg::T_MAX}) b.t = psf_rqt_pkg::T_MAX;
      else b.t = tdiff[16:0];
    end else if (i == psf_rqt_pkg::ST_W) begin
      tt  = {17'b0, b.t} * {17'b0, b.t};
      b.w = tt[32:2];
    end else if (i <= psf_rqt_pkg::ST_C) begin
      // horner steps of the cosine polynomial
      pin  = (i == psf_rqt_pkg::ST_P4) ? psf_rqt_pkg::COS_A5 : b.p;
      prod = {31'b0, pin} * {31'b0, b.w};
      case (i)
        psf_rqt_pkg::ST_P4:     coef = psf_rqt_pkg::COS_A4;
        psf_rqt_pkg::ST_P4 + 1: coef = psf_rqt_pkg::COS_A3;
        psf_rqt_pkg::ST_P4 + 2: coef = psf_rqt_pkg::COS_A2;
        default:                coef = psf_rqt_pkg::COS_A1;
      endcase
      if (i <= psf_rqt_pkg::ST_P1) begin
        b.p = coef - prod[60:30];
      end else begin
        cs = {2'b0, psf_rqt_pkg::Q30_ONE} - {2'b0, prod[60:30]};
        b.c = cs[32] ? 31'd0 : cs[30:0];
      end
    end else if (i == psf_rqt_pkg::ST_FACTOR) begin
      prod = ({31'b0, b.c} * {31'b0, b.c}) + (62'd1 << 44);
      b.f  = prod[60:45];
    end else if (i == psf_rqt_pkg::ST_SCALE) begin
      sc = ({16'b0, b.mag} * {32'b0, b.f}) + 48'd16384;
      if (b.zero) b.mag = '0;
      else if (b.taper) b.mag = sc[46:15];
    end else begin
      if (b.neg) b.mag = ~b.mag + 32'd1;
    end
    stage_fn = b;
  endfunction

  psf_rqt_pkg::bk_t pipe [NS];
  logic [NS-1:0]    vld;
  logic             en;

  // whole pipeline moves unless the last beat is held
  assign en  = !vld[NS-1] || m_tready;
  assign pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], q_valid};
    end
  end

  // entry stage: sign split and root setup
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].nx    <= q_data.nx;
      pipe[0].ny    <= q_data.ny;
      pipe[0].idx   <= q_data.idx;
      pipe[0].plane <= q_data.plane;
      pipe[0].neg   <= q_data.raw[31];
      pipe[0].zero  <= q_data.zero;
      pipe[0].taper <= q_data.taper;
      pipe[0].mag   <= q_data.raw[31] ? (~q_data.raw + 32'd1) : q_data.raw;
      pipe[0].rem   <= {q_data.r2, 32'b0};
      pipe[0].root  <= '0;
      pipe[0].drem  <= '0;
      pipe[0].dq    <= '0;
      pipe[0].t     <= '0;
      pipe[0].w     <= '0;
      pipe[0].p     <= '0;
      pipe[0].c     <= '0;
      pipe[0].f     <= '0;
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) pipe[g] <= stage_fn(pipe[g-1], g, sw);
    end
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {2'b0, pipe[NS-1].mag, pipe[NS-1].plane, pipe[NS-1].idx,
                     pipe[NS-1].ny, pipe[NS-1].nx};

  `PRQT_ASSERT_NEXT(a_hold_on_stall, !en, vld == $past(vld), "pipeline moved while stalled")
  `PRQT_ASSERT_NOW(a_pop_needs_move, pop, en && q_valid, "pop without pipeline advance")
  `PRQT_ASSERT_NEXT(a_entry_tracks_pop, en, vld[0] == $past(q_valid), "entry stage missed a pop")

endmodule

FILE: design/psf_resize_quadrant_taper.sv
// each kept input beat is registered through the front stages, the queue and the back pipeline to its output beat
// throughput: one beat per cycle; input stalls only while the output is held and the queue fills
// dropped pixels give no output beat and leave the flow at the accepting edge
// reset (rst, synchronous): registers to reset values, queue and pipeline empty
// top level: config registers, front, queue and back
// depends on psf_rqt_pkg, psf_rqt_front, psf_rqt_queue, psf_rqt_back
`timescale 1ns / 1ps

module psf_resize_quadrant_taper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // src_x, src_y, plane, pixel_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // dst_x, dst_y, dst_index, out_plane, tapered_value
);

  logic [8:0] src_width, src_height, dst_width, dst_height;
  logic [6:0] num_coeffs;
  psf_rqt_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'd64;
      src_height <= 9'd64;
      dst_width  <= 9'd128;
      dst_height <= 9'd128;
      num_coeffs <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        psf_rqt_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        psf_rqt_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        psf_rqt_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
        psf_rqt_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
        psf_rqt_pkg::REG_NUM_COEFFS: num_coeffs <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported grid and plane counts
  always_comb begin
    cfg.sw = (src_width  > 9'(psf_rqt_pkg::MAX_DIM)) ? 9'(psf_rqt_pkg::MAX_DIM) : src_width;
    cfg.sh = (src_height > 9'(psf_rqt_pkg::MAX_DIM)) ? 9'(psf_rqt_pkg::MAX_DIM) : src_height;
    cfg.dw = (dst_width  > 9'(psf_rqt_pkg::MAX_DIM)) ? 9'(psf_rqt_pkg::MAX_DIM) : dst_width;
    cfg.dh = (dst_height > 9'(psf_rqt_pkg::MAX_DIM)) ? 9'(psf_rqt_pkg::MAX_DIM) : dst_height;
    cfg.nc = (num_coeffs > 7'(psf_rqt_pkg::MAX_PLANES)) ? 7'(psf_rqt_pkg::MAX_PLANES)
                                                        : num_coeffs;
  end

  logic                         push, pop, q_valid;
  psf_rqt_pkg::fr_t             push_data, q_data;
  logic [psf_rqt_pkg::Q_CW-1:0] q_count;

  psf_rqt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  psf_rqt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .count     (q_count)
  );

  psf_rqt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .sw       (cfg.sw),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
